// ===== sv/ksm_pkg.sv =====
// Shared types and constants for the key sequence matcher.
package ksm_pkg;

    localparam int NUM_SLOTS       = 8;
    localparam int SLOT_BYTES      = 7;
    localparam int SLOT_W          = 8 * SLOT_BYTES;
    localparam int SLOT_IDX_W      = 3;
    localparam int MAX_SEQ_LEN_DEF = 7;
    // Wide enough for any length or binding length (at most 7)
    localparam int CNT_W           = 4;
    localparam int KEY_W           = 8;
    localparam int CHAR_W          = 21;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_RUNE = 1'b1;

    typedef enum logic [2:0] {
        ACT_INSERT_KEY  = 3'd0,
        ACT_RUN         = 3'd1,
        ACT_WAIT        = 3'd2,
        ACT_DISCARD     = 3'd3,
        ACT_INSERT_RUNE = 3'd4
    } t_action;

    typedef struct packed {
        logic              opcode;
        logic [KEY_W-1:0]  key_code;
        logic [CHAR_W-1:0] rune_value;
    } t_in_item;

    typedef struct packed {
        t_action               action;
        logic [SLOT_IDX_W-1:0] binding_index;
        logic [CHAR_W-1:0]     char_out;
    } t_out_item;

    typedef struct packed {
        logic exact;
        logic prefix;
    } t_slot_hit;

endpackage

// ===== sv/ksm_slot_cmp.sv =====
// Compare the pending key sequence with one binding slot.
module ksm_slot_cmp #(
    parameter int MAX_SEQ_LEN = ksm_pkg::MAX_SEQ_LEN_DEF,
    parameter int LEN_W       = $clog2(MAX_SEQ_LEN + 1)
) (
    input  logic [ksm_pkg::SLOT_W-1:0]           i_slot,
    input  logic [MAX_SEQ_LEN-1:0][7:0]          i_pend,
    input  logic [LEN_W-1:0]                     i_len,
    output ksm_pkg::t_slot_hit                   o_hit
);
    import ksm_pkg::*;

    localparam int CMP_N = (MAX_SEQ_LEN < SLOT_BYTES) ? MAX_SEQ_LEN : SLOT_BYTES;

    logic [CNT_W-1:0] blen;
    logic [CNT_W-1:0] len_x;
    logic             run_on;
    logic             same;
    logic             hit;

    // Binding length: bytes before the first zero byte
    always_comb begin
        blen   = '0;
        run_on = 1'b1;
        for (int k = 0; k < SLOT_BYTES; k++) begin
            if (run_on && (i_slot[8*k +: 8] != 8'h00)) begin
                blen = blen + CNT_W'(1);
            end else begin
                run_on = 1'b0;
            end
        end
    end

    // Bytes beyond the binding length never count: hit needs len <= blen
    always_comb begin
        same = 1'b1;
        for (int k = 0; k < CMP_N; k++) begin
            if ((CNT_W'(k) < len_x) && (i_pend[k] != i_slot[8*k +: 8])) begin
                same = 1'b0;
            end
        end
    end

    assign len_x        = CNT_W'(i_len);
    assign hit          = (blen != '0) && (len_x <= blen) && same;
    assign o_hit.exact  = hit && (len_x == blen);
    assign o_hit.prefix = hit && (len_x < blen);

endmodule

// ===== sv/key_sequence_matcher_core.sv =====
// Top level of the key sequence matcher: pending sequence, bindings and result register.
// An accepted transaction's result is registered in the output register.
// Throughput: one transaction per cycle unless a held result stalls input; eight slot
//   comparators and sequence update are combinational; a key sees the prior key's state.
// Reset (synchronous, active low) empties the pending sequence, clears every binding
//   slot to zero and empties the output register.
module key_sequence_matcher_core #(
    parameter int MAX_SEQ_LEN = ksm_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ksm_pkg::t_in_item                   i_in_item,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ksm_pkg::t_out_item                  o_out_item,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ksm_pkg::SLOT_IDX_W-1:0]      i_cfg_index,
    input  logic [ksm_pkg::SLOT_W-1:0]          i_cfg_data
);
    import ksm_pkg::*;

    localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);
    localparam int IDX_W = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;

    logic [SLOT_W-1:0]           r_slot [NUM_SLOTS];
    logic [MAX_SEQ_LEN-1:0][7:0] r_pend;
    logic [MAX_SEQ_LEN-1:0][7:0] n_pend;
    logic [LEN_W-1:0]            r_len;
    logic [LEN_W-1:0]            n_len;
    logic [LEN_W-1:0]            grown_len;
    logic                        r_out_valid;
    t_out_item                   r_out;
    t_out_item                   n_out;
    t_slot_hit                   slot_hit [NUM_SLOTS];
    logic                        any_exact;
    logic                        any_prefix;
    logic [SLOT_IDX_W-1:0]       exact_idx;
    logic                        in_accept;

    // Bindings are plain registers; writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_slot[s] <= '0;
            end
        end else if (i_cfg_valid) begin
            r_slot[i_cfg_index] <= i_cfg_data;
        end
    end

    // Hold the result register while the consumer stalls; otherwise take a new item
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Append the key to the pending sequence. The length never reaches
    // MAX_SEQ_LEN here, since a wait only keeps a grown length below it.
    assign grown_len = r_len + LEN_W'(1);

    always_comb begin
        n_pend = r_pend;
        n_pend[r_len[IDX_W-1:0]] = i_in_item.key_code;
    end

    generate
        for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
            ksm_slot_cmp #(
                .MAX_SEQ_LEN (MAX_SEQ_LEN),
                .LEN_W       (LEN_W)
            ) u_cmp (
                .i_slot (r_slot[s]),
                .i_pend (n_pend),
                .i_len  (grown_len),
                .o_hit  (slot_hit[s])
            );
        end
    endgenerate

    // Lowest exact slot wins; walk downwards so the last write is the lowest
    always_comb begin
        any_exact  = 1'b0;
        any_prefix = 1'b0;
        exact_idx  = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (slot_hit[s].exact) begin
                any_exact = 1'b1;
                exact_idx = SLOT_IDX_W'(s);
            end
            if (slot_hit[s].prefix) begin
                any_prefix = 1'b1;
            end
        end
    end

    // Decide the action. Every outcome except wait drops the pending sequence.
    always_comb begin
        n_out.action        = ACT_DISCARD;
        n_out.binding_index = '0;
        n_out.char_out      = '0;
        n_len               = '0;
        if (i_in_item.opcode == OP_RUNE) begin
            n_out.action   = ACT_INSERT_RUNE;
            n_out.char_out = i_in_item.rune_value;
        end else if (any_exact) begin
            n_out.action        = ACT_RUN;
            n_out.binding_index = exact_idx;
        end else if (any_prefix && (grown_len < LEN_W'(MAX_SEQ_LEN))) begin
            n_out.action = ACT_WAIT;
            n_len        = grown_len;
        end else if (!any_prefix && (grown_len == LEN_W'(1))) begin
            n_out.action   = ACT_INSERT_KEY;
            n_out.char_out = CHAR_W'(i_in_item.key_code);
        end
    end

    // Pending bytes beyond the length are never compared, so only the length resets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (in_accept) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_in_item.opcode == OP_KEY)) begin
            r_pend <= n_pend;
        end
    end

    // Result register: load on acceptance, empty once the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The pending sequence is never left full
    a_len_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len < LEN_W'(MAX_SEQ_LEN))
        else $error("pending length reached the maximum");

    // Any transaction that does not wait leaves an empty sequence
    a_clear_unless_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (n_out.action != ACT_WAIT)) |=> (r_len == '0))
        else $error("pending sequence not cleared");

    // A wait result grows the sequence by exactly one byte
    a_wait_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (n_out.action == ACT_WAIT)) |=> (r_len == $past(r_len) + LEN_W'(1)))
        else $error("wait did not extend the pending sequence");

    // Only insert actions carry a character
    a_char_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action != ACT_INSERT_KEY)
                     && (r_out.action != ACT_INSERT_RUNE)) |-> (r_out.char_out == '0))
        else $error("character present on a non-insert result");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the key sequence matcher core.
module tb;
    import ksm_pkg::*;

    localparam int SEQ_MAX    = MAX_SEQ_LEN_DEF;
    localparam int PRINT_CAP  = 100;
    localparam int DRAIN_CAP  = 100000;

    // Binding sets loaded between phases
    typedef enum int {
        PLAN_EDITOR,
        PLAN_OVERLAP,
        PLAN_RANDOM
    } t_binding_plan;

    // Receiver back-pressure styles
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURSTY
    } t_stall_style;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SLOT_IDX_W-1:0] cfg_index = '0;
    logic [SLOT_W-1:0]     cfg_data  = '0;

    // Shadow of the block: binding slots and the pending key sequence
    logic [SLOT_W-1:0] bind_copy [NUM_SLOTS];
    logic [KEY_W-1:0]  seq_buf   [SEQ_MAX];
    int                seq_len;

    // Keystrokes waiting to be sent, and the outcomes they are owed
    t_in_item  stroke_q    [$];
    t_out_item due_actions [$];

    int n_errors   = 0;
    int burst_left = 1;
    int gap_left   = 0;

    t_stall_style stall_style = STALL_NONE;
    int           style_left  = 0;
    int           stall_run   = 0;

    key_sequence_matcher_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Number of bytes before the first zero byte; bytes past it are junk
    function automatic int binding_length(input logic [SLOT_W-1:0] b);
        int n;
        n = 0;
        while (n < SLOT_BYTES && b[8*n +: 8] != 8'h00)
            n++;
        return n;
    endfunction

    function automatic void clear_sequence();
        seq_len = 0;
        foreach (seq_buf[i])
            seq_buf[i] = 8'h00;
    endfunction

    // Work out the outcome of one keystroke or rune and advance the shadow
    // sequence exactly as the block should.
    function automatic t_out_item resolve_stroke(input t_in_item it);
        t_out_item r;
        int        blen;
        int        k;
        int        exact_slot;
        bit        exact_hit;
        bit        prefix_hit;
        bit        same;
        r          = '0;
        exact_slot = 0;
        exact_hit  = 1'b0;
        prefix_hit = 1'b0;
        // A rune flushes whatever was pending and goes straight through
        if (it.opcode == OP_RUNE) begin
            clear_sequence();
            r.action   = ACT_INSERT_RUNE;
            r.char_out = it.rune_value;
            return r;
        end
        if (seq_len >= SEQ_MAX)
            clear_sequence();
        seq_buf[seq_len] = it.key_code;
        seq_len++;
        // Compare against every slot; the lowest exact slot wins
        for (int s = 0; s < NUM_SLOTS; s++) begin
            blen = binding_length(bind_copy[s]);
            if (blen != 0 && seq_len <= blen) begin
                same = 1'b1;
                for (k = 0; k < seq_len; k++)
                    if (seq_buf[k] != bind_copy[s][8*k +: 8])
                        same = 1'b0;
                if (same && seq_len == blen) begin
                    if (!exact_hit) begin
                        exact_hit  = 1'b1;
                        exact_slot = s;
                    end
                end else if (same) begin
                    prefix_hit = 1'b1;
                end
            end
        end
        if (exact_hit) begin
            clear_sequence();
            r.action        = ACT_RUN;
            r.binding_index = SLOT_IDX_W'(exact_slot);
        end else if (prefix_hit && seq_len < SEQ_MAX) begin
            r.action = ACT_WAIT;
        end else if (!prefix_hit && seq_len == 1) begin
            clear_sequence();
            r.action   = ACT_INSERT_KEY;
            r.char_out = CHAR_W'(it.key_code);
        end else begin
            // Dead end or a full sequence: drop it
            clear_sequence();
            r.action = ACT_DISCARD;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Key press; the rune field is ignored by the block, so fill it with noise
    function automatic void queue_key(input logic [KEY_W-1:0] key);
        t_in_item t;
        t.opcode     = OP_KEY;
        t.key_code   = key;
        t.rune_value = CHAR_W'($urandom_range(0, 32'h10FFFF));
        stroke_q.push_back(t);
    endfunction

    function automatic void queue_rune(input logic [CHAR_W-1:0] cp, input logic [KEY_W-1:0] junk);
        t_in_item t;
        t.opcode     = OP_RUNE;
        t.key_code   = junk;
        t.rune_value = cp;
        stroke_q.push_back(t);
    endfunction

    // Off-sequence key: often a byte that some binding uses, sometimes anything
    function automatic logic [KEY_W-1:0] stray_key();
        logic [SLOT_W-1:0] b;
        int                len;
        int                k;
        b   = bind_copy[$urandom_range(0, NUM_SLOTS - 1)];
        len = binding_length(b);
        if (len > 0 && $urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, len - 1);
            return b[8*k +: 8];
        end
        if ($urandom_range(0, 15) == 0)
            return 8'h00;
        return KEY_W'($urandom_range(1, 255));
    endfunction

    // Mostly real binding sequences, whole or cut short, mixed with stray keys and runes
    task automatic queue_traffic(input int n_items);
        int                made;
        int                len;
        int                cut;
        int                pick;
        logic [SLOT_W-1:0] b;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                b   = bind_copy[$urandom_range(0, NUM_SLOTS - 1)];
                len = binding_length(b);
                if (len == 0) begin
                    queue_key(stray_key());
                    made++;
                end else begin
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
                    for (int k = 0; k < cut; k++)
                        queue_key(b[8*k +: 8]);
                    made += cut;
                end
            end else if (pick < 8) begin
                queue_key(stray_key());
                made++;
            end else begin
                queue_rune(CHAR_W'($urandom_range(0, 32'h10FFFF)),
                           KEY_W'($urandom_range(0, 255)));
                made++;
            end
        end
    endtask

    // One register write; the shadow slot follows on acceptance
    task automatic write_binding(input int idx, input logic [SLOT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= SLOT_IDX_W'(idx);
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        bind_copy[idx] = val;
    endtask

    task automatic load_bindings(input t_binding_plan plan);
        logic [KEY_W-1:0]  alpha [4];
        logic [SLOT_W-1:0] val;
        int                len;
        // A small alphabet keeps random bindings overlapping
        foreach (alpha[i])
            alpha[i] = KEY_W'($urandom_range(1, 255));
        for (int s = 0; s < NUM_SLOTS; s++) begin
            val = '0;
            if (plan == PLAN_EDITOR) begin
                case (s)
                    0: val = 56'h00000000000318;
                    1: val = 56'h00000000001318;
                    2: val = 56'h00000000011818;
                    3: val = 56'h00000000415B1B;
                    4: val = 56'h00000000425B1B;
                    5: val = 56'h17161514131211;
                    6: val = 56'hFFFFFFFFFFFFFF;
                    default: val = '0;
                endcase
            end else if (plan == PLAN_OVERLAP) begin
                // Slots 1 and 2 both spell one byte, slot 1 with junk past its end;
                // slot 3 extends it; slot 7 repeats slot 5 with junk.
                case (s)
                    1: val = 56'hABCDEF00000041;
                    2: val = 56'h00000000000041;
                    3: val = 56'h00000000004241;
                    4: val = 56'h00000000000001;
                    5: val = 56'h000000000000FF;
                    6: val = 56'h00000000020180;
                    7: val = 56'hFFFFFFFFFF00FF;
                    default: val = '0;
                endcase
            end else if ($urandom_range(0, 7) != 0) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, SLOT_BYTES)
                                                  : $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    val[8*k +: 8] = alpha[$urandom_range(0, 3)];
                if (len < SLOT_BYTES - 1 && $urandom_range(0, 3) == 0)
                    for (int k = len + 1; k < SLOT_BYTES; k++)
                        val[8*k +: 8] = KEY_W'($urandom_range(0, 255));
            end
            write_binding(s, val);
        end
    endtask

    // Hold until nothing is queued, in flight or owed; sampled away from the active edge
    task automatic wait_quiet();
        int waited;
        waited = 0;
        do begin
            @(negedge clk);
            waited++;
        end while ((stroke_q.size() > 0 || in_valid || due_actions.size() > 0)
                   && waited < DRAIN_CAP);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        if (n_errors < PRINT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions separated by random gaps. A payload
    // stays put while stalled; a new one is only launched once the
    // current transaction has gone or the channel is empty.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : feed
        bit launch;
        launch = 1'b0;
        if (rst_n) begin
            if (in_valid && !in_stall)
                due_actions.push_back(resolve_stroke(in_item));
            if (in_valid && in_stall) begin
                // hold the stalled transaction
                launch = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (stroke_q.size() > 0) begin
                launch = 1'b1;
                in_item <= stroke_q.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    // long back-to-back stretch
                    burst_left = $urandom_range(20, 60);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(1, 6);
                end
            end
        end
        in_valid <= launch;
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest owed outcome,
    // and drive the receiver's stall from a style that changes now and then.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch
        t_out_item want;
        bit        hold;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (due_actions.size() == 0) begin
                if (n_errors < PRINT_CAP)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_item);
                n_errors++;
            end else begin
                want = due_actions.pop_front();
                if (out_item.action !== want.action)
                    report_mismatch("action", want.action, out_item.action);
                if (out_item.binding_index !== want.binding_index)
                    report_mismatch("binding_index", want.binding_index,
                                    out_item.binding_index);
                if (out_item.char_out !== want.char_out)
                    report_mismatch("char_out", want.char_out, out_item.char_out);
            end
        end

        if (style_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            style_left  = $urandom_range(50, 400);
        end else begin
            style_left--;
        end
        case (stall_style)
            STALL_NONE: begin
                hold = 1'b0;
            end
            STALL_LIGHT: begin
                hold = ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                hold = ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    hold = 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_run = $urandom_range(1, 12);
                    hold      = 1'b1;
                end else begin
                    hold = 1'b0;
                end
            end
        endcase
        out_stall <= hold;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence. Bindings change only with the block drained, so
    // each phase boundary also makes the sender wait for every result.
    // ------------------------------------------------------------------
    initial begin : stimulus
        foreach (bind_copy[i])
            bind_copy[i] = '0;
        clear_sequence();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty slots: every key goes straight through, zero and all-ones bytes included
        queue_key(8'h00);
        queue_key(8'hFF);
        queue_key(8'h01);
        queue_rune(21'h10FFFF, 8'hFF);
        queue_rune(21'h000000, 8'hAA);
        queue_rune(21'h0F0000, 8'h55);
        wait_quiet();

        load_bindings(PLAN_EDITOR);
        queue_key(8'h18);                 // wait, then run slot 0
        queue_key(8'h03);
        queue_key(8'h18);                 // wrong second key: discard
        queue_key(8'h41);
        queue_key(8'h1B);                 // rune breaks a pending sequence
        queue_rune(21'h01F600, 8'h1B);
        for (int k = 0; k < SLOT_BYTES; k++)
            queue_key(KEY_W'(8'h11 + k)); // longest binding
        queue_key(8'h18);                 // zero byte inside a sequence
        queue_key(8'h00);
        wait_quiet();

        load_bindings(PLAN_OVERLAP);
        queue_key(8'h41);                 // two exact slots plus a longer prefix
        queue_key(8'hFF);
        queue_key(8'h80);
        queue_key(8'h01);
        queue_key(8'h02);
        wait_quiet();

        // Random phases: one with the fixed editor set, the rest with random sets
        for (int ph = 0; ph < 7; ph++) begin
            load_bindings(ph == 0 ? PLAN_EDITOR : PLAN_RANDOM);
            queue_traffic(250);
            wait_quiet();
        end

        repeat (8) @(posedge clk);
        if (n_errors == 0 && due_actions.size() == 0 && stroke_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (due_actions.size() > 0)
                $display("%0t: %0d results never arrived", $time, due_actions.size());
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin : watchdog
        #8000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== key_sequence_matcher_core.f =====
sv/ksm_pkg.sv
sv/ksm_slot_cmp.sv
sv/key_sequence_matcher_core.sv
dv/tb.sv
